FILE: rtl/core/msh_pkg.sv
// Shared types and constants of the multichannel spectrum histogrammer.
`timescale 1ns / 1ps
`default_nettype none

package msh_pkg;

   // Command codes
   typedef enum logic [1:0] {
      CMD_COUNT = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_LOCATE,
      ST_READ,
      ST_WORK,
      ST_HOLD
   } state_type;

   // Payload field widths
   localparam int CMD_W       = 2;
   localparam int WORD_W      = 32;
   localparam int SEL_CHIP_W  = 2;
   localparam int SEL_CHAN_W  = 5;
   localparam int BIN_FIELD_W = 14;
   localparam int VALUE_W     = 32;

   // Event word layout
   localparam int EV_CHIP_LSB = 24;
   localparam int EV_CHAN_LSB = 16;
   localparam int EV_BIN_LSB  = 2;
   localparam int CHIP_W      = 8;
   localparam int CHAN_W      = 8;

   // Bin wrap: quotient by reciprocal multiply
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 23;
   localparam int QUOT_W      = 7;
   localparam int RPROD_W     = BIN_FIELD_W + RECIP_W;
   localparam int REM_CALC_W  = 24;
   localparam int ROW_CALC_W  = 17;

endpackage

`default_nettype wire

FILE: rtl/core/msh_if.sv
// Request and response channel interfaces of the histogrammer.
`timescale 1ns / 1ps
`default_nettype none

interface msh_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [msh_pkg::CMD_W-1:0]             cmd;
   logic [msh_pkg::WORD_W-1:0]            event_word;
   logic [msh_pkg::SEL_CHIP_W-1:0]        sel_chip;
   logic [msh_pkg::SEL_CHAN_W-1:0]        sel_channel;
   logic [msh_pkg::BIN_FIELD_W-1:0]       sel_bin;

   modport source (
      output valid, cmd, event_word, sel_chip, sel_channel, sel_bin,
      input  ready
   );
   modport sink (
      input  valid, cmd, event_word, sel_chip, sel_channel, sel_bin,
      output ready
   );
endinterface

interface msh_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [msh_pkg::VALUE_W-1:0]   count_value;
   logic                          ignored;
   logic                          dropped_bad_channel;
   logic                          saturated;

   modport source (
      output valid, count_value, ignored, dropped_bad_channel, saturated,
      input  ready
   );
   modport sink (
      input  valid, count_value, ignored, dropped_bad_channel, saturated,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/msh_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module msh_ram #(
   parameter int     WIDTH  = 32,
   parameter longint DEPTH  = 1024,
   parameter int     ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/multichannel_spectrum_histogrammer.sv
// Top level: per-chip, per-channel energy histograms with saturating counters.
//
//   channel | dir | transfer carries
//   --------+-----+----------------------------------------------------------
//   req     | in  | cmd, event_word, sel_chip, sel_channel, sel_bin
//   rsp     | out | count_value, ignored, dropped_bad_channel, saturated
//
// One item at a time: accept, row/quotient multiply, bin wrap and base
// multiply, memory read, then modify and write back with the result loaded.
// A stalled rsp holds the result in a side register and delays the next accept.
// After reset a clearing pass writes zero to every counter, one entry a cycle,
// NUM_CHIPS*CHANNEL_ROWS*NUM_BINS entries (835584 at defaults), req.ready low.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_spectrum_histogrammer #(
   parameter int NUM_CHIPS    = 3,
   parameter int CHANNEL_ROWS = 17,
   parameter int NUM_BINS     = 16384,
   parameter int COUNT_WIDTH  = 32
) (
   input wire logic clock,
   input wire logic reset,
   msh_req_if.sink   req,
   msh_rsp_if.source rsp
);

   localparam int     ROWS_TOTAL = NUM_CHIPS * CHANNEL_ROWS;
   localparam int     ROW_W      = (ROWS_TOTAL > 1) ? $clog2(ROWS_TOTAL) : 1;
   localparam int     BIN_W      = $clog2(NUM_BINS);
   localparam longint DEPTH      = longint'(ROWS_TOTAL) * longint'(NUM_BINS);
   localparam int     ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int     BASE_PW    = ROW_W + 17;
   localparam logic [msh_pkg::RECIP_W-1:0] RECIP =
      msh_pkg::RECIP_W'((longint'(1) << msh_pkg::RECIP_SHIFT) / NUM_BINS + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   msh_pkg::state_type state_ff, state_in;

   logic [ADDR_W-1:0]                  clr_addr_ff, clr_addr_in;
   logic [msh_pkg::CMD_W-1:0]          cmd_ff, cmd_in;
   logic                               ign_ff, ign_in;
   logic                               bad_ff, bad_in;
   logic [msh_pkg::CHIP_W-1:0]         chip_ff, chip_in;
   logic [msh_pkg::CHAN_W-1:0]         chan_ff, chan_in;
   logic [msh_pkg::BIN_FIELD_W-1:0]    bin_ff, bin_in;
   logic [ROW_W-1:0]                   row_ff, row_in;
   logic [msh_pkg::QUOT_W-1:0]         quot_ff, quot_in;
   logic [ADDR_W-1:0]                  base_ff, base_in;
   logic [BIN_W-1:0]                   rem_ff, rem_in;
   logic [ADDR_W-1:0]                  addr_ff, addr_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [msh_pkg::VALUE_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                               rsp_ign_ff, rsp_ign_in;
   logic                               rsp_bad_ff, rsp_bad_in;
   logic                               rsp_sat_ff, rsp_sat_in;

   logic [msh_pkg::VALUE_W-1:0]        hold_value_ff, hold_value_in;
   logic                               hold_ign_ff, hold_ign_in;
   logic                               hold_bad_ff, hold_bad_in;
   logic                               hold_sat_ff, hold_sat_in;

   logic                               req_fire;
   logic                               out_free;

   logic                               ram_wr_en;
   logic [ADDR_W-1:0]                  ram_wr_addr;
   logic [COUNT_WIDTH-1:0]             ram_wr_data;
   logic                               ram_rd_en;
   logic [ADDR_W-1:0]                  ram_rd_addr;
   logic [COUNT_WIDTH-1:0]             ram_rd_data;

   // Datapath temporaries
   logic [msh_pkg::CHIP_W-1:0]         dec_chip;
   logic [msh_pkg::CHAN_W-1:0]         dec_chan;
   logic [msh_pkg::BIN_FIELD_W-1:0]    dec_bin;
   logic [msh_pkg::ROW_CALC_W-1:0]     row_wide;
   logic [msh_pkg::RPROD_W-1:0]        recip_prod;
   logic [msh_pkg::REM_CALC_W-1:0]     rem_diff;
   logic [BASE_PW-1:0]                 base_prod;
   logic                               entry_ok;
   logic                               is_count;
   logic                               is_read;
   logic                               is_clear;
   logic                               at_max;
   logic [COUNT_WIDTH-1:0]             new_count;
   logic [msh_pkg::VALUE_W-1:0]        res_value;
   logic                               res_sat;

   assign req.ready = (state_ff == msh_pkg::ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.count_value         = rsp_value_ff;
   assign rsp.ignored             = rsp_ign_ff;
   assign rsp.dropped_bad_channel = rsp_bad_ff;
   assign rsp.saturated           = rsp_sat_ff;

   msh_ram #(
      .WIDTH  (COUNT_WIDTH),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msh_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = msh_pkg::ST_IDLE;
            end
         end
         msh_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = msh_pkg::ST_MAP;
            end
         end
         msh_pkg::ST_MAP:    state_in = msh_pkg::ST_LOCATE;
         msh_pkg::ST_LOCATE: state_in = msh_pkg::ST_READ;
         msh_pkg::ST_READ:   state_in = msh_pkg::ST_WORK;
         msh_pkg::ST_WORK: begin
            state_in = out_free ? msh_pkg::ST_IDLE : msh_pkg::ST_HOLD;
         end
         msh_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = msh_pkg::ST_IDLE;
            end
         end
         default: state_in = msh_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      // decode at accept
      if (req.cmd == msh_pkg::CMD_COUNT) begin
         dec_chip = req.event_word[msh_pkg::EV_CHIP_LSB +: msh_pkg::CHIP_W];
         dec_chan = req.event_word[msh_pkg::EV_CHAN_LSB +: msh_pkg::CHAN_W];
         dec_bin  = req.event_word[msh_pkg::EV_BIN_LSB +: msh_pkg::BIN_FIELD_W];
      end else begin
         dec_chip = msh_pkg::CHIP_W'(req.sel_chip);
         dec_chan = msh_pkg::CHAN_W'(req.sel_channel);
         dec_bin  = req.sel_bin;
      end

      cmd_in  = cmd_ff;
      ign_in  = ign_ff;
      bad_in  = bad_ff;
      chip_in = chip_ff;
      chan_in = chan_ff;
      bin_in  = bin_ff;
      if (req_fire) begin
         cmd_in  = req.cmd;
         chip_in = dec_chip;
         chan_in = dec_chan;
         bin_in  = dec_bin;
         ign_in  = (req.cmd != msh_pkg::CMD_NOP) &&
                   ((dec_chip == '0) || (dec_chip > msh_pkg::CHIP_W'(NUM_CHIPS)));
         bad_in  = (req.cmd != msh_pkg::CMD_NOP) && !ign_in &&
                   ({1'b0, dec_chan} >= (msh_pkg::CHAN_W + 1)'(CHANNEL_ROWS));
      end

      // row index and bin quotient
      row_wide   = msh_pkg::ROW_CALC_W'(chip_ff - msh_pkg::CHIP_W'(1)) *
                   msh_pkg::ROW_CALC_W'(CHANNEL_ROWS) +
                   msh_pkg::ROW_CALC_W'(chan_ff);
      row_in     = ROW_W'(row_wide);
      recip_prod = msh_pkg::RPROD_W'(bin_ff) * msh_pkg::RPROD_W'(RECIP);
      quot_in    = recip_prod[msh_pkg::RECIP_SHIFT +: msh_pkg::QUOT_W];

      // bin wrap remainder and row base
      rem_diff = msh_pkg::REM_CALC_W'(bin_ff) -
                 msh_pkg::REM_CALC_W'(quot_ff) * msh_pkg::REM_CALC_W'(NUM_BINS);
      if (rem_diff >= msh_pkg::REM_CALC_W'(NUM_BINS)) begin
         rem_diff = rem_diff - msh_pkg::REM_CALC_W'(NUM_BINS);
      end
      rem_in    = BIN_W'(rem_diff);
      base_prod = BASE_PW'(row_ff) * BASE_PW'(NUM_BINS);
      base_in   = ADDR_W'(base_prod);

      ram_rd_addr = base_ff + ADDR_W'(rem_ff);
      ram_rd_en   = (state_ff == msh_pkg::ST_READ);
      addr_in     = (state_ff == msh_pkg::ST_READ) ? ram_rd_addr : addr_ff;

      // modify
      entry_ok  = !ign_ff && !bad_ff;
      is_count  = entry_ok && (cmd_ff == msh_pkg::CMD_COUNT);
      is_read   = entry_ok && (cmd_ff == msh_pkg::CMD_READ);
      is_clear  = entry_ok && (cmd_ff == msh_pkg::CMD_CLEAR);
      at_max    = (ram_rd_data == COUNT_MAX);
      new_count = at_max ? ram_rd_data : ram_rd_data + COUNT_WIDTH'(1);
      res_sat   = is_count && at_max;
      if (is_count) begin
         res_value = msh_pkg::VALUE_W'(new_count);
      end else if (is_read) begin
         res_value = msh_pkg::VALUE_W'(ram_rd_data);
      end else begin
         res_value = '0;
      end

      // write port: clearing pass or write-back
      clr_addr_in = clr_addr_ff;
      if (state_ff == msh_pkg::ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
      end else begin
         ram_wr_en   = (state_ff == msh_pkg::ST_WORK) && (is_count || is_clear);
         ram_wr_addr = addr_ff;
         ram_wr_data = is_clear ? '0 : new_count;
      end

      // result path
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_ign_in    = rsp_ign_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_sat_in    = rsp_sat_ff;
      hold_value_in = hold_value_ff;
      hold_ign_in   = hold_ign_ff;
      hold_bad_in   = hold_bad_ff;
      hold_sat_in   = hold_sat_ff;
      if (state_ff == msh_pkg::ST_WORK) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = res_value;
            rsp_ign_in   = ign_ff;
            rsp_bad_in   = bad_ff;
            rsp_sat_in   = res_sat;
         end else begin
            hold_value_in = res_value;
            hold_ign_in   = ign_ff;
            hold_bad_in   = bad_ff;
            hold_sat_in   = res_sat;
         end
      end else if ((state_ff == msh_pkg::ST_HOLD) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = hold_value_ff;
         rsp_ign_in   = hold_ign_ff;
         rsp_bad_in   = hold_bad_ff;
         rsp_sat_in   = hold_sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msh_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ign_ff        <= ign_in;
      bad_ff        <= bad_in;
      chip_ff       <= chip_in;
      chan_ff       <= chan_in;
      bin_ff        <= bin_in;
      row_ff        <= row_in;
      quot_ff       <= quot_in;
      base_ff       <= base_in;
      rem_ff        <= rem_in;
      addr_ff       <= addr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_ign_ff    <= rsp_ign_in;
      rsp_bad_ff    <= rsp_bad_in;
      rsp_sat_ff    <= rsp_sat_in;
      hold_value_ff <= hold_value_in;
      hold_ign_ff   <= hold_ign_in;
      hold_bad_ff   <= hold_bad_in;
      hold_sat_ff   <= hold_sat_in;
   end

endmodule

`default_nettype wire
